/* src/lsm_pkg.sv */
// ----------------------------------------------------------------------------
// lsm_pkg: shared definitions of the line substring matcher
// Types, register indexes, reset values and helper functions used by the
// configuration block, the compare cells and the top level.
// ----------------------------------------------------------------------------
package lsm_pkg;

  localparam int unsigned PatternMax = 8;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned PatternW   = 64;
  localparam int unsigned LenW       = 4;
  localparam int unsigned ColW       = 8;
  localparam int unsigned LimitW     = 10;
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [PatternW-1:0] PatternReset = '0;
  localparam logic [LenW-1:0]     LengthReset  = 4'd1;
  localparam logic                FoldReset    = 1'b1;
  localparam logic [ColW-1:0]     ColumnsReset = 8'd80;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATTERN_BYTES  = 3'd0,
    CFG_PATTERN_LENGTH = 3'd1,
    CFG_FOLD_CASE      = 3'd2,
    CFG_LINE_COLUMNS   = 3'd3
  } cfg_index_e;

  // Settings as seen by the datapath, with the length already clamped.
  typedef struct packed {
    logic [PatternW-1:0]     pattern;
    logic [LenW-1:0]         length;
    logic                    fold;
    logic signed [LimitW-1:0] limit;
  } cfg_t;

  // Maps a to z onto A to Z when folding is on.
  function automatic logic [ByteW-1:0] fold_byte(logic [ByteW-1:0] b, logic fold);
    logic [ByteW-1:0] r;
    r = b;
    if (fold && (b >= 8'h61) && (b <= 8'h7A)) begin
      r = b - 8'h20;
    end
    return r;
  endfunction

  // Pattern byte that window position pos must match: byte length-1-pos.
  function automatic logic [ByteW-1:0] pattern_for_pos(logic [PatternW-1:0] p,
                                                       logic [LenW-1:0] length,
                                                       logic [LenW-1:0] pos);
    logic [LenW-1:0] idx;
    idx = length - 4'd1 - pos;
    return p[idx[2:0]*ByteW +: ByteW];
  endfunction

endpackage

/* src/line_substring_matcher_top.sv */
// ----------------------------------------------------------------------------
// line_substring_matcher_top: streaming substring search over text lines
// Searches each line for a configured pattern and reports the earliest match.
// ----------------------------------------------------------------------------
// The block takes one text byte per item, in column order. It accepts a new
// item in every cycle unless two results are waiting on the master side:
// results go to an output register and, when that one is still occupied,
// to a second register behind it, so the input only stalls after a second
// line end has arrived while the first result is still not taken. A row of
// PATTERN_MAX cells holds the most recent bytes of the line; with each
// accepted item the row shifts by one and every cell compares its byte
// with the pattern byte that belongs to its position, so the match that ends
// at the current byte is known in the same cycle. A match counts only if it
// starts at or after the resume column of the item and below line_columns
// minus the pattern length minus one; the first such match of the line is
// kept. The item marked with tlast closes the line: one result item appears
// on the master side in the next cycle if the output register is free, held
// there until taken, and the line state clears. Other items give no result.
// Configuration writes are always ready and must only be made while no line
// is in progress and no result is pending. Lines longer than 255 bytes are
// allowed; their later bytes can never start a match.
// ----------------------------------------------------------------------------
module line_substring_matcher_top #(
  parameter int unsigned PATTERN_MAX = lsm_pkg::PatternMax
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lsm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lsm_pkg::PatternW-1:0] cfg_data_i,
  // Text input: tdata = text_byte [7:0], resume_column [15:8]; tlast = end_of_line.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,
  input  logic                         s_axis_tlast,
  // Result output: tdata = match_end_column [7:0]; tuser = found [0].
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,
  output logic [0:0]                   m_axis_tuser
);

  lsm_pkg::cfg_t cfg;

  logic                        accept;
  logic [lsm_pkg::ByteW-1:0]   text_byte;
  logic [lsm_pkg::ColW-1:0]    resume_col;

  logic [lsm_pkg::ByteW-1:0]   chain   [PATTERN_MAX+1];
  logic [PATTERN_MAX-1:0]      cell_hit;

  logic [lsm_pkg::ColW-1:0]    col_q, col_d;
  logic                        seen_q, seen_d;
  logic [lsm_pkg::ColW-1:0]    end_q, end_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_found_q, out_found_d;
  logic [lsm_pkg::ColW-1:0]    out_end_q, out_end_d;
  logic                        skid_valid_q, skid_valid_d;
  logic                        skid_found_q, skid_found_d;
  logic [lsm_pkg::ColW-1:0]    skid_end_q, skid_end_d;

  logic [lsm_pkg::ColW:0]         col_next;
  logic signed [lsm_pkg::LimitW-1:0] start_col;
  logic                        start_ok;
  logic                        new_hit;
  logic                        res_found;
  logic [lsm_pkg::ColW-1:0]    res_end;

  lsm_cfg_regs #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign text_byte  = s_axis_tdata[7:0];
  assign resume_col = s_axis_tdata[15:8];

  // The input side runs as long as the second result register is empty.
  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Cell 0 receives the new byte; every further cell receives its left
  // neighbor's stored byte, which makes the row a shifting window.
  assign chain[0] = text_byte;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    lsm_cell u_cell (
      .clk_i      (clk_i),
      .shift_en_i (accept),
      .byte_i     (chain[j]),
      .pat_byte_i (lsm_pkg::pattern_for_pos(cfg.pattern, cfg.length,
                                            lsm_pkg::LenW'(j))),
      .fold_i     (cfg.fold),
      .active_i   (lsm_pkg::LenW'(j) < cfg.length),
      .byte_o     (chain[j+1]),
      .hit_o      (cell_hit[j])
    );
  end

  // Start column of the match that would end at the current byte. A negative
  // value means the line is still shorter than the pattern.
  assign col_next  = {1'b0, col_q} + 9'd1;
  assign start_col = $signed({1'b0, col_next}) - $signed({6'b000000, cfg.length});
  assign start_ok  = (start_col >= 10'sd0) &&
                     (start_col >= $signed({2'b00, resume_col})) &&
                     (start_col < cfg.limit);
  assign new_hit   = !seen_q && start_ok && (&cell_hit);

  // Result of the line that closes with the current item.
  assign res_found = seen_q || new_hit;
  assign res_end   = seen_q  ? end_q :
                     new_hit ? col_next[lsm_pkg::ColW-1:0] : '0;

  always_comb begin
    col_d        = col_q;
    seen_d       = seen_q;
    end_d        = end_q;
    out_valid_d  = out_valid_q;
    out_found_d  = out_found_q;
    out_end_d    = out_end_q;
    skid_valid_d = skid_valid_q;
    skid_found_d = skid_found_q;
    skid_end_d   = skid_end_q;

    // A taken result makes room; the waiting one moves up.
    if (out_valid_q && m_axis_tready) begin
      out_valid_d  = skid_valid_q;
      out_found_d  = skid_found_q;
      out_end_d    = skid_end_q;
      skid_valid_d = 1'b0;
    end

    if (accept) begin
      if (new_hit) begin
        seen_d = 1'b1;
        end_d  = col_next[lsm_pkg::ColW-1:0];
      end
      if (col_q != 8'hFF) begin
        col_d = col_next[lsm_pkg::ColW-1:0];
      end
      if (s_axis_tlast) begin
        if (out_valid_d) begin
          skid_valid_d = 1'b1;
          skid_found_d = res_found;
          skid_end_d   = res_end;
        end else begin
          out_valid_d = 1'b1;
          out_found_d = res_found;
          out_end_d   = res_end;
        end
        col_d  = '0;
        seen_d = 1'b0;
        end_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      seen_q       <= 1'b0;
      end_q        <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      col_q        <= col_d;
      seen_q       <= seen_d;
      end_q        <= end_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_found_q  <= out_found_d;
    out_end_q    <= out_end_d;
    skid_found_q <= skid_found_d;
    skid_end_q   <= skid_end_d;
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_end_q;
  assign m_axis_tuser[0] = out_found_q;

endmodule

/* src/lsm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lsm_cfg_regs: configuration registers of the line substring matcher
// Holds the four registers and derives the clamped length and the start limit.
// ----------------------------------------------------------------------------
module lsm_cfg_regs #(
  parameter int unsigned PATTERN_MAX = lsm_pkg::PatternMax
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lsm_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [lsm_pkg::PatternW-1:0]       cfg_data_i,
  output lsm_pkg::cfg_t                      cfg_o
);

  logic [lsm_pkg::PatternW-1:0] pattern_q;
  logic [lsm_pkg::LenW-1:0]     length_q;
  logic                         fold_q;
  logic [lsm_pkg::ColW-1:0]     columns_q;
  logic [lsm_pkg::LenW-1:0]     eff_len;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= lsm_pkg::PatternReset;
      length_q  <= lsm_pkg::LengthReset;
      fold_q    <= lsm_pkg::FoldReset;
      columns_q <= lsm_pkg::ColumnsReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lsm_pkg::CFG_PATTERN_BYTES:  pattern_q <= cfg_data_i;
        lsm_pkg::CFG_PATTERN_LENGTH: length_q  <= cfg_data_i[lsm_pkg::LenW-1:0];
        lsm_pkg::CFG_FOLD_CASE:      fold_q    <= cfg_data_i[0];
        lsm_pkg::CFG_LINE_COLUMNS:   columns_q <= cfg_data_i[lsm_pkg::ColW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_len = length_q;
    if (length_q == '0) begin
      eff_len = 4'd1;
    end else if (length_q > lsm_pkg::LenW'(PATTERN_MAX)) begin
      eff_len = lsm_pkg::LenW'(PATTERN_MAX);
    end
  end

  assign cfg_o.pattern = pattern_q;
  assign cfg_o.length  = eff_len;
  assign cfg_o.fold    = fold_q;
  assign cfg_o.limit   = $signed({2'b00, columns_q}) - $signed({6'b000000, eff_len})
                         - 10'sd1;

endmodule

/* src/lsm_cell.sv */
// ----------------------------------------------------------------------------
// lsm_cell: one window position of the matcher
// Stores one recent text byte, passes it on to the next cell on every
// accepted item, and compares the byte it receives against its pattern byte.
// ----------------------------------------------------------------------------
module lsm_cell (
  input  logic                       clk_i,
  input  logic                       shift_en_i,
  input  logic [lsm_pkg::ByteW-1:0]  byte_i,
  input  logic [lsm_pkg::ByteW-1:0]  pat_byte_i,
  input  logic                       fold_i,
  input  logic                       active_i,
  output logic [lsm_pkg::ByteW-1:0]  byte_o,
  output logic                       hit_o
);

  logic [lsm_pkg::ByteW-1:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

  // The incoming byte is this position's content once the item is taken.
  assign hit_o = !active_i ||
                 (lsm_pkg::fold_byte(byte_i, fold_i) == lsm_pkg::fold_byte(pat_byte_i, fold_i));

endmodule

/* tb/line_match_checker.sv */
// ----------------------------------------------------------------------------
// line_match_checker: result checker for the line substring matcher
// Watches the configuration, text and result channels, keeps its own copy of
// the registers and of the line state, works out the result of every line and
// compares it with what the block delivers.
// ----------------------------------------------------------------------------
module line_match_checker
  import lsm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [PatternW-1:0] cfg_data_i,
  input  logic                text_valid_i,
  input  logic                text_ready_i,
  input  logic [15:0]         text_data_i,  // text_byte [7:0], resume_column [15:8]
  input  logic                text_last_i,
  input  logic                result_valid_i,
  input  logic                result_ready_i,
  input  logic [7:0]          result_data_i,  // match_end_column [7:0]
  input  logic [0:0]          result_user_i,  // found [0]
  output int                  pending_o,
  output int                  errors_o
);

  typedef struct packed {
    logic       found;
    logic [7:0] stop_col;
  } line_result_t;

  // Register copies.
  logic [PatternW-1:0] pattern_q;
  logic [LenW-1:0]     length_q;
  logic                fold_q;
  logic [ColW-1:0]     columns_q;

  // Line state; window_q[0] holds the newest byte.
  logic [7:0] window_q [8];
  logic [7:0] column_q;
  logic       seen_q;
  logic [7:0] stop_q;

  line_result_t line_results [$];
  int           mismatch_count;

  function automatic logic [7:0] fold_letter(logic [7:0] b, logic on);
    if (on && (b >= 8'h61) && (b <= 8'h7A)) begin
      return b - 8'h20;
    end
    return b;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("line_match_checker: %0t: %s", $realtime, what);
    end
  endtask

  task automatic clear_line();
    foreach (window_q[k]) window_q[k] = '0;
    column_q = '0;
    seen_q   = 1'b0;
    stop_q   = '0;
  endtask

  // Advances the line state by one text byte and queues the line result on
  // the last byte of the line.
  task automatic scan_byte(input logic [7:0] b, input logic eol, input logic [7:0] resume);
    int           span;
    int           first;
    int           bound;
    logic         hit;
    line_result_t res;
    if (length_q == 0) span = 1;
    else if (length_q > PatternMax) span = PatternMax;
    else span = length_q;
    for (int k = 7; k > 0; k--) window_q[k] = window_q[k-1];
    window_q[0] = b;
    first = int'(column_q) + 1 - span;
    bound = int'(columns_q) - span - 1;
    if (!seen_q && (first >= 0) && (first >= int'(resume)) && (first < bound)) begin
      hit = 1'b1;
      for (int i = 0; i < span; i++) begin
        if (fold_letter(pattern_q[8*i +: 8], fold_q) !=
            fold_letter(window_q[span-1-i], fold_q)) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        seen_q = 1'b1;
        stop_q = column_q + 8'd1;
      end
    end
    if (column_q != 8'hFF) column_q = column_q + 8'd1;
    if (eol) begin
      res.found    = seen_q;
      res.stop_col = seen_q ? stop_q : 8'd0;
      line_results.push_back(res);
      clear_line();
    end
  endtask

  task automatic check_result();
    line_result_t want;
    if (line_results.size() == 0) begin
      flag_mismatch($sformatf("result found=%0d column=%0d with no line pending",
                              result_user_i[0], result_data_i));
      return;
    end
    want = line_results.pop_front();
    if (result_user_i[0] !== want.found) begin
      flag_mismatch($sformatf("found is %b, expected %b", result_user_i[0], want.found));
    end
    if (result_data_i !== want.stop_col) begin
      flag_mismatch($sformatf("match_end_column is %0d, expected %0d",
                              result_data_i, want.stop_col));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q      = PatternReset;
      length_q       = LengthReset;
      fold_q         = FoldReset;
      columns_q      = ColumnsReset;
      clear_line();
      line_results.delete();
      mismatch_count = 0;
      pending_o     <= 0;
      errors_o      <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PATTERN_BYTES:  pattern_q = cfg_data_i;
          CFG_PATTERN_LENGTH: length_q  = cfg_data_i[LenW-1:0];
          CFG_FOLD_CASE:      fold_q    = cfg_data_i[0];
          CFG_LINE_COLUMNS:   columns_q = cfg_data_i[ColW-1:0];
          default: ;
        endcase
      end
      if (result_valid_i && result_ready_i) check_result();
      if (text_valid_i && text_ready_i) begin
        scan_byte(text_data_i[7:0], text_last_i, text_data_i[15:8]);
      end
      pending_o <= line_results.size();
      errors_o  <= mismatch_count;
    end
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench of the line substring matcher
// Drives text lines and register settings into the block, lets the checker
// predict and compare every line result, and gives the verdict.
// ----------------------------------------------------------------------------
// The run starts with a handful of directed lines: a match under the reset
// settings, a case-folded match, a match held back by the resume column, an
// exact-case match with folding off, single-byte lines at the byte extremes,
// and a line width too small for any match. Then follow phases of random
// lines, each phase under new register settings (pattern lengths that clamp
// at both ends, widths at both extremes among them). Most random lines carry
// the pattern, sometimes with letters in the other case, at a random place;
// the rest are noise, single bytes, or lines longer than 255 bytes.
// Registers are only written while no line is open and no result is pending.
// The sender works in bursts with random gaps and the receiver switches
// between several stall modes.
// ----------------------------------------------------------------------------
module tb_top;
  import lsm_pkg::*;

  localparam int RandomItems = 2000;
  localparam int PhaseCount  = 12;
  localparam int CycleLimit  = 400000;
  // An index with no register behind it; writes to it must be ignored.
  localparam logic [CfgIdxW-1:0] CfgSpare = 3'd7;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_EVERY_FOURTH,
    RX_SCARCE
  } rx_mode_e;

  logic                clk_i;
  logic                rst_ni         = 1'b0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [PatternW-1:0] cfg_data_i     = '0;
  logic                s_axis_tvalid  = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata   = '0;  // text_byte [7:0], resume_column [15:8]
  logic                s_axis_tlast   = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready  = 1'b0;
  logic [7:0]          m_axis_tdata;   // match_end_column [7:0]
  logic [0:0]          m_axis_tuser;   // found [0]

  int pending_lines;
  int error_count;
  int cycle_count = 0;

  // Stimulus state: the line being built and what the pattern looks like.
  logic [7:0] line_text [$];
  logic [7:0] pat_bytes [8];
  int         pat_span;
  logic       fold_on;
  int         burst_left = 0;

  rx_mode_e   rx_mode  = RX_OPEN;
  int         rx_count = 0;

  line_substring_matcher_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  line_match_checker line_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .text_valid_i   (s_axis_tvalid),
    .text_ready_i   (s_axis_tready),
    .text_data_i    (s_axis_tdata),
    .text_last_i    (s_axis_tlast),
    .result_valid_i (m_axis_tvalid),
    .result_ready_i (m_axis_tready),
    .result_data_i  (m_axis_tdata),
    .result_user_i  (m_axis_tuser),
    .pending_o      (pending_lines),
    .errors_o       (error_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: a run that hangs on a handshake or never delivers a pending
  // result ends here as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // The receiver changes its stall mode at random: always ready, coin toss,
  // one cycle in four, or ready only now and then.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_mode       <= RX_OPEN;
      rx_count      <= 0;
    end else begin
      if (rx_count == 0) begin
        rx_mode  <= rx_mode_e'($urandom_range(0, 3));
        rx_count <= $urandom_range(16, 200);
      end else begin
        rx_count <= rx_count - 1;
      end
      case (rx_mode)
        RX_OPEN:         m_axis_tready <= 1'b1;
        RX_COIN:         m_axis_tready <= 1'($urandom_range(0, 1));
        RX_EVERY_FOURTH: m_axis_tready <= (rx_count % 4 == 0);
        default:         m_axis_tready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // One register write; cfg_valid_i stays high so that writes can follow
  // back to back. write_regs lowers it after the batch.
  task automatic cfg_put(input logic [CfgIdxW-1:0] index, input logic [PatternW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Writes all four registers. Bits above each register's width carry random
  // values, which the block must drop.
  task automatic write_regs(input logic [63:0] pattern, input logic [3:0] length,
                            input logic fold, input logic [7:0] columns);
    logic [63:0] noise;
    noise = {$urandom(), $urandom()};
    cfg_put(CFG_PATTERN_BYTES, pattern);
    cfg_put(CFG_PATTERN_LENGTH, {noise[63:4], length});
    cfg_put(CFG_FOLD_CASE, {noise[62:0], fold});
    cfg_put(CFG_LINE_COLUMNS, {noise[55:0], columns});
    cfg_valid_i <= 1'b0;
    foreach (pat_bytes[k]) pat_bytes[k] = pattern[8*k +: 8];
    if (length == 0) pat_span = 1;
    else if (length > PatternMax) pat_span = PatternMax;
    else pat_span = length;
    fold_on = fold;
  endtask

  // Presents one item and waits for it to be taken. A new burst starts with
  // a random gap with tvalid low.
  task automatic push_item(input logic [7:0] b, input logic eol, input logic [7:0] resume);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {resume, b};
    s_axis_tlast  <= eol;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Sends line_text as one line. The resume column normally stays fixed over
  // the line; with jitter set, each byte carries a random one.
  task automatic send_line(input logic [7:0] resume, input bit jitter);
    logic [7:0] r;
    foreach (line_text[k]) begin
      r = jitter ? 8'($urandom_range(0, line_text.size())) : resume;
      push_item(line_text[k], k == line_text.size() - 1, r);
    end
  endtask

  task automatic queue_text(input string s);
    line_text.delete();
    for (int k = 0; k < s.len(); k++) line_text.push_back(s[k]);
  endtask

  // Waits until no line result is outstanding, then idles so that the output
  // register can settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_lines != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] flip_case(input logic [7:0] b);
    logic [7:0] low;
    low = b | 8'h20;
    if ((low >= 8'h61) && (low <= 8'h7A) && ($urandom_range(0, 1) == 1)) begin
      return b ^ 8'h20;
    end
    return b;
  endfunction

  // Builds a random line. Most bytes are pattern bytes or letters so that
  // partial matches are frequent; most lines also get the whole pattern.
  task automatic make_line();
    int   n;
    int   roll;
    int   at;
    logic [7:0] b;
    roll = $urandom_range(0, 99);
    if (roll < 2) n = $urandom_range(256, 300);
    else if (roll < 10) n = 1;
    else if (roll < 25) n = $urandom_range(60, 200);
    else n = $urandom_range(2, 50);
    line_text.delete();
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 65) b = flip_case(pat_bytes[$urandom_range(0, pat_span - 1)]);
      else if (roll < 85) b = 8'($urandom_range(8'h41, 8'h5A)) | 8'($urandom_range(0, 1) * 8'h20);
      else b = 8'($urandom_range(0, 255));
      line_text.push_back(b);
    end
    if ((n >= pat_span) && ($urandom_range(0, 99) < 70)) begin
      at = $urandom_range(0, n - pat_span);
      for (int i = 0; i < pat_span; i++) begin
        line_text[at + i] = ($urandom_range(0, 3) == 0) ? flip_case(pat_bytes[i])
                                                        : pat_bytes[i];
      end
    end
  endtask

  initial begin : stimulus
    int         phase;
    int         phase_items;
    int         roll;
    logic [63:0] pattern;
    logic [3:0]  length;
    logic [7:0]  columns;
    logic [7:0]  resume;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings search for a single zero byte.
    line_text = '{8'h41, 8'h00, 8'h42};
    send_line(8'd0, 1'b0);
    drain();

    // "AbC" with folding on; the unused upper pattern bytes hold garbage.
    write_regs(64'h5A5A_5A5A_5A43_6241, 4'd3, 1'b1, 8'd80);
    queue_text("xaBcq");
    send_line(8'd0, 1'b0);
    // The first occurrence lies before the resume column, the second counts.
    queue_text("abcabc");
    send_line(8'd2, 1'b0);
    drain();

    // Folding off: only the exact-case copy matches.
    write_regs(64'h5A5A_5A5A_5A43_6241, 4'd3, 1'b0, 8'd80);
    queue_text("abcAbC");
    send_line(8'd0, 1'b0);
    // Single-byte lines at the byte and column extremes.
    line_text = '{8'hFF};
    send_line(8'hFF, 1'b0);
    line_text = '{8'h00};
    send_line(8'd0, 1'b0);
    drain();

    // Line width too small for any start column.
    write_regs(64'h5A5A_5A5A_5A43_6241, 4'd3, 1'b0, 8'd0);
    queue_text("AbC");
    send_line(8'd0, 1'b0);
    drain();

    for (phase = 0; phase < PhaseCount; phase++) begin
      pattern = '0;
      for (int k = 0; k < 8; k++) begin
        pattern[8*k +: 8] = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(8'h41, 8'h5A))
                                                         | 8'($urandom_range(0, 1) * 8'h20)
                                                       : 8'($urandom_range(0, 255));
      end
      roll = $urandom_range(0, 99);
      length = (roll < 75) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 15));
      roll = $urandom_range(0, 99);
      if (roll < 10) columns = 8'($urandom_range(0, 15));
      else if (roll < 20) columns = 8'd255;
      else columns = 8'($urandom_range(16, 255));
      // The first phases pin the extremes of the pattern, length and line-width registers.
      case (phase)
        0: begin
          pattern = '1;
          length  = 4'd8;
          columns = 8'd255;
          cfg_put(CfgSpare, {$urandom(), $urandom()});
        end
        1: begin
          length  = 4'd0;
          columns = 8'd16;
        end
        2: begin
          length  = 4'd15;
          columns = 8'd255;
        end
        3: columns = 8'($urandom_range(0, 10));
        default: ;
      endcase
      write_regs(pattern, length, 1'($urandom_range(0, 1)), columns);

      phase_items = 0;
      while (phase_items < RandomItems / PhaseCount) begin
        make_line();
        phase_items += line_text.size();
        roll = $urandom_range(0, 99);
        if (roll < 45) resume = 8'd0;
        else if (roll < 85) resume = 8'($urandom_range(0, line_text.size()));
        else resume = 8'($urandom_range(0, 255));
        send_line(resume, $urandom_range(0, 19) == 0);
      end
      drain();
    end

    repeat (16) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
